// File: src/mec_pkg.sv
// shared types, constants and helper functions of the escape-time colorizer
// no dependencies
package mec_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_REAL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_IMAG   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_REAL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_IMAG     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_CYCLES = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREY_MODE     = 3'd5;

   localparam logic signed [31:0] ORIGIN_RESET = -32'sd536870912;
   localparam logic [30:0]        STEP_RESET   = 31'd1048576;
   localparam logic [6:0]         CYCLES_RESET = 7'd1;

   localparam int unsigned HUE_PERIOD  = 1530;
   localparam int unsigned GREY_PERIOD = 510;
   localparam int unsigned PAL_ENTRIES = 128;
   localparam int unsigned PHASE_W     = 11;

   localparam logic [PHASE_W-1:0] SEG_1 = 11'd255;
   localparam logic [PHASE_W-1:0] SEG_2 = 11'd510;
   localparam logic [PHASE_W-1:0] SEG_3 = 11'd765;
   localparam logic [PHASE_W-1:0] SEG_4 = 11'd1020;
   localparam logic [PHASE_W-1:0] SEG_5 = 11'd1275;
   localparam logic [PHASE_W-1:0] SEG_6 = 11'd1530;

   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [63:0] S32_MIN = 64'shffff_ffff_8000_0000;

   typedef struct packed {
      logic [9:0] column;
      logic [9:0] row;
   } req_payload_type;

   typedef struct packed {
      logic [8:0] iterations;
      logic       inside_res;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [31:0] origin_real;
      logic signed [31:0] origin_imag;
      logic [30:0]        step_real;
      logic [30:0]        step_imag;
      logic [6:0]         palette_cycles;
      logic               grey_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] cr;
      logic signed [31:0] ci;
   } point_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITER,
      ST_FINISH
   } engine_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = S32_MAX[31:0];
      end else if (v < S32_MIN) begin
         r = S32_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: src/mec_front.sv
// front end: clamps the pixel indices and forms the point c = origin + index * step
// depends on mec_pkg
module mec_front #(
   parameter int unsigned COLUMNS = 1024,
   parameter int unsigned ROWS    = 1024
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mec_pkg::req_payload_type req_data,
   input  mec_pkg::cfg_type         cfg,
   output logic                     push_valid,
   input  logic                     push_ready,
   output mec_pkg::point_type       push_data
);

   localparam int unsigned COL_LAST = COLUMNS - 1;
   localparam int unsigned ROW_LAST = ROWS - 1;

   logic [9:0]         col_eff;
   logic [9:0]         row_eff;
   logic [40:0]        prod_re;
   logic [40:0]        prod_im;
   logic signed [63:0] wide_re;
   logic signed [63:0] wide_im;

   // clamp indices beyond the frame
   always_comb begin
      col_eff = (32'(req_data.column) >= 32'(COLUMNS)) ? COL_LAST[9:0] : req_data.column;
      row_eff = (32'(req_data.row) >= 32'(ROWS)) ? ROW_LAST[9:0] : req_data.row;
   end

   assign prod_re = 41'(col_eff) * 41'(cfg.step_real);
   assign prod_im = 41'(row_eff) * 41'(cfg.step_imag);

   assign wide_re = {{32{cfg.origin_real[31]}}, cfg.origin_real} + $signed({23'd0, prod_re});
   assign wide_im = {{32{cfg.origin_imag[31]}}, cfg.origin_imag} + $signed({23'd0, prod_im});

   assign push_valid   = req_valid;
   assign req_ready    = push_ready;
   assign push_data.cr = mec_pkg::sat32(wide_re);
   assign push_data.ci = mec_pkg::sat32(wide_im);

endmodule

// File: src/mec_fifo.sv
// short queue of points between the front end and the iteration engine
// depends on mec_pkg
module mec_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mec_pkg::point_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mec_pkg::point_type pop_data
);

   localparam int unsigned AW = mec_pkg::FIFO_AW;
   localparam int unsigned DEPTH = mec_pkg::FIFO_DEPTH;

   mec_pkg::point_type entry_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff;
   logic [AW-1:0]      wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff;
   logic [AW-1:0]      rd_ptr_in;
   logic [AW:0]        fill_ff;
   logic [AW:0]        fill_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (fill_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/mec_engine.sv
// back end: iterates z = z*z + c one step per cycle, tracks the palette phase
// and maps the escape count to a colour; depends on mec_pkg
module mec_engine #(
   parameter int unsigned MAX_ITER      = 256,
   parameter int unsigned FRACTION_BITS = 28
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mec_pkg::cfg_type         cfg,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  mec_pkg::point_type       pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mec_pkg::rsp_payload_type rsp_data
);

   localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);
   localparam int unsigned PW    = mec_pkg::PHASE_W;
   localparam logic [63:0] ESC_LIMIT = 64'd4 << FRACTION_BITS;

   mec_pkg::engine_state_type state_ff;
   mec_pkg::engine_state_type state_in;

   logic signed [31:0] cr_ff, cr_in;
   logic signed [31:0] ci_ff, ci_in;
   logic signed [31:0] zr_ff, zr_in;
   logic signed [31:0] zi_ff, zi_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PW-1:0]      m_ff, m_in;
   logic [PW-1:0]      step_ff, step_in;
   logic [PW-1:0]      period_ff, period_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mec_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [PW-1:0] hue_step_tbl  [mec_pkg::PAL_ENTRIES];
   logic [PW-1:0] grey_step_tbl [mec_pkg::PAL_ENTRIES];

   logic signed [63:0] rr;
   logic signed [63:0] ii;
   logic signed [63:0] ri;
   logic [63:0]        mag_sum;
   logic signed [63:0] diff;
   logic signed [63:0] nr;
   logic signed [63:0] ni;
   logic               escape;
   logic               at_limit;
   logic [PW:0]        m_sum;
   logic [PW-1:0]      m_next;
   logic               in_set;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   mec_pkg::rsp_payload_type colour;

   // per-iteration phase advance, already reduced by the period
   for (genvar k = 0; k < mec_pkg::PAL_ENTRIES; k++) begin : g_scale
      localparam int unsigned HUE_STEP =
         ((mec_pkg::HUE_PERIOD * k) / MAX_ITER) % mec_pkg::HUE_PERIOD;
      localparam int unsigned GREY_STEP =
         ((mec_pkg::GREY_PERIOD * k) / MAX_ITER) % mec_pkg::GREY_PERIOD;
      assign hue_step_tbl[k]  = HUE_STEP[PW-1:0];
      assign grey_step_tbl[k] = GREY_STEP[PW-1:0];
   end

   // one iteration step
   assign rr      = zr_ff * zr_ff;
   assign ii      = zi_ff * zi_ff;
   assign ri      = zr_ff * zi_ff;
   assign mag_sum = $unsigned(rr) + $unsigned(ii);
   assign escape  = (mag_sum >> FRACTION_BITS) >= ESC_LIMIT;
   assign at_limit = (count_ff == CNT_W'(MAX_ITER));
   assign diff    = rr - ii;
   assign nr      = (diff >>> FRACTION_BITS) + $signed({{32{cr_ff[31]}}, cr_ff});
   assign ni      = (ri >>> (FRACTION_BITS - 1)) + $signed({{32{ci_ff[31]}}, ci_ff});

   assign m_sum  = {1'b0, m_ff} + {1'b0, step_ff};
   assign m_next = (m_sum >= {1'b0, period_ff}) ? PW'(m_sum - {1'b0, period_ff}) : PW'(m_sum);

   // colour map
   always_comb begin
      red   = '0;
      green = '0;
      blue  = '0;
      in_set = at_limit;
      if (in_set) begin
         red   = {8{cfg.grey_mode}};
         green = {8{cfg.grey_mode}};
         blue  = {8{cfg.grey_mode}};
      end else if (cfg.grey_mode) begin
         red   = (m_ff < mec_pkg::SEG_1) ? 8'(m_ff) : 8'(mec_pkg::SEG_2 - m_ff);
         green = red;
         blue  = red;
      end else if (m_ff <= mec_pkg::SEG_1) begin
         green = 8'(m_ff);
         blue  = 8'hff;
      end else if (m_ff <= mec_pkg::SEG_2) begin
         green = 8'hff;
         blue  = 8'(mec_pkg::SEG_2 - m_ff);
      end else if (m_ff <= mec_pkg::SEG_3) begin
         red   = 8'(m_ff - mec_pkg::SEG_2);
         green = 8'hff;
      end else if (m_ff <= mec_pkg::SEG_4) begin
         red   = 8'hff;
         green = 8'(mec_pkg::SEG_4 - m_ff);
      end else if (m_ff <= mec_pkg::SEG_5) begin
         red   = 8'hff;
         blue  = 8'(m_ff - mec_pkg::SEG_4);
      end else begin
         red   = 8'(mec_pkg::SEG_6 - m_ff);
         blue  = 8'hff;
      end
      colour.iterations = 9'(count_ff);
      colour.inside_res = in_set;
      colour.red        = red;
      colour.green      = green;
      colour.blue       = blue;
   end

   always_comb begin
      state_in     = state_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      m_in         = m_ff;
      step_in      = step_ff;
      period_in    = period_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pop_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         mec_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cr_in     = pop_data.cr;
               ci_in     = pop_data.ci;
               zr_in     = '0;
               zi_in     = '0;
               count_in  = '0;
               m_in      = '0;
               step_in   = cfg.grey_mode ? grey_step_tbl[cfg.palette_cycles]
                                         : hue_step_tbl[cfg.palette_cycles];
               period_in = cfg.grey_mode ? PW'(mec_pkg::GREY_PERIOD)
                                         : PW'(mec_pkg::HUE_PERIOD);
               state_in  = mec_pkg::ST_ITER;
            end
         end
         mec_pkg::ST_ITER: begin
            if (escape || at_limit) begin
               state_in = mec_pkg::ST_FINISH;
            end else begin
               zr_in    = mec_pkg::sat32(nr);
               zi_in    = mec_pkg::sat32(ni);
               count_in = count_ff + 1'b1;
               m_in     = m_next;
            end
         end
         mec_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = colour;
               state_in     = mec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mec_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mec_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         m_ff         <= '0;
         period_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         m_ff         <= m_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITER))
      else $error("iteration count beyond limit");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == mec_pkg::ST_ITER |-> m_ff < period_ff)
      else $error("palette phase not reduced");

   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.inside_res |-> rsp_data_ff.iterations == 9'(MAX_ITER))
      else $error("inside flag without full count");

   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == mec_pkg::ST_FINISH && !(rsp_valid_ff && !rsp_ready) |=>
         rsp_valid_ff && state_ff == mec_pkg::ST_IDLE)
      else $error("finished transaction not delivered");
`endif

endmodule

// File: src/mandelbrot_escape_time_colorizer_top.sv
// top level of the escape-time colorizer: register file, front end, queue, engine
// depends on mec_pkg, mec_front, mec_fifo, mec_engine
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_data   (column, row)
// rsp      out        rsp_valid / rsp_ready  rsp_data   (iterations, inside_res, rgb)
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// in the engine a pixel is loaded, iterated until it escapes or its count reaches MAX_ITER,
// one z*z + c step per iteration, and then coloured
// the front end and a two-entry queue take new pixels while the engine works
// the result register frees the engine as soon as the previous transaction is taken
// reset is synchronous; csr_ready is always high
module mandelbrot_escape_time_colorizer_top #(
   parameter int unsigned MAX_ITER      = 256,
   parameter int unsigned COLUMNS       = 1024,
   parameter int unsigned ROWS          = 1024,
   parameter int unsigned FRACTION_BITS = 28
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mec_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mec_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mec_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   mec_pkg::cfg_type   cfg_ff;
   mec_pkg::cfg_type   cfg_in;
   logic               push_valid;
   logic               push_ready;
   mec_pkg::point_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   mec_pkg::point_type pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mec_pkg::CSR_ORIGIN_REAL:    cfg_in.origin_real    = $signed(csr_wdata);
            mec_pkg::CSR_ORIGIN_IMAG:    cfg_in.origin_imag    = $signed(csr_wdata);
            mec_pkg::CSR_STEP_REAL:      cfg_in.step_real      = csr_wdata[30:0];
            mec_pkg::CSR_STEP_IMAG:      cfg_in.step_imag      = csr_wdata[30:0];
            mec_pkg::CSR_PALETTE_CYCLES: cfg_in.palette_cycles = csr_wdata[6:0];
            mec_pkg::CSR_GREY_MODE:      cfg_in.grey_mode      = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_real    <= mec_pkg::ORIGIN_RESET;
         cfg_ff.origin_imag    <= mec_pkg::ORIGIN_RESET;
         cfg_ff.step_real      <= mec_pkg::STEP_RESET;
         cfg_ff.step_imag      <= mec_pkg::STEP_RESET;
         cfg_ff.palette_cycles <= mec_pkg::CYCLES_RESET;
         cfg_ff.grey_mode      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mec_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mec_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mec_engine #(
      .MAX_ITER      (MAX_ITER),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/mec_pixel_checker.sv
// checker of the escape-time colorizer: tracks register writes, predicts each pixel and
// compares every rsp transaction with the oldest prediction
// depends on mec_pkg
`timescale 1ns / 100ps
module mec_pixel_checker #(
   parameter int unsigned MAX_ITER      = 256,
   parameter int unsigned COLUMNS       = 1024,
   parameter int unsigned ROWS          = 1024,
   parameter int unsigned FRACTION_BITS = 28
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  mec_pkg::req_payload_type        req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  mec_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              pending_count
);

   localparam logic signed [63:0] WORD_MAX  = 64'sd2147483647;
   localparam logic signed [63:0] WORD_MIN  = -64'sd2147483648;
   localparam logic [63:0]        ESCAPE_AT = 64'd4 << FRACTION_BITS;

   logic signed [31:0] origin_re;
   logic signed [31:0] origin_im;
   logic [30:0]        step_re;
   logic [30:0]        step_im;
   logic [6:0]         cycles;
   logic               grey;

   mec_pkg::rsp_payload_type pending_pixels[$];
   mec_pkg::rsp_payload_type oldest;

   function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic mec_pkg::rsp_payload_type colour_pixel(
      input mec_pkg::req_payload_type px);
      int unsigned        col;
      int unsigned        row;
      int unsigned        count;
      int unsigned        scale;
      int unsigned        phase;
      int unsigned        shade;
      logic signed [63:0] base;
      logic signed [63:0] pos;
      logic signed [63:0] stride;
      logic signed [63:0] cr;
      logic signed [63:0] ci;
      logic signed [63:0] zr;
      logic signed [63:0] zi;
      logic signed [63:0] rr;
      logic signed [63:0] ii;
      logic signed [63:0] nr;
      logic signed [63:0] ni;
      logic [63:0]        mag;
      mec_pkg::rsp_payload_type res;

      col = (32'(px.column) >= COLUMNS) ? COLUMNS - 1 : 32'(px.column);
      row = (32'(px.row) >= ROWS) ? ROWS - 1 : 32'(px.row);

      base = 64'(origin_re);
      pos = 64'(col);
      stride = {33'd0, step_re};
      cr = clamp_word(base + pos * stride);
      base = 64'(origin_im);
      pos = 64'(row);
      stride = {33'd0, step_im};
      ci = clamp_word(base + pos * stride);

      zr = 0;
      zi = 0;
      rr = 0;
      ii = 0;
      mag = 0;
      count = 0;
      while (((mag >> FRACTION_BITS) < ESCAPE_AT) && (count < MAX_ITER)) begin
         nr = ((rr - ii) >>> FRACTION_BITS) + cr;
         ni = ((zr * zi) >>> (FRACTION_BITS - 1)) + ci;
         zr = clamp_word(nr);
         zi = clamp_word(ni);
         rr = zr * zr;
         ii = zi * zi;
         mag = rr + ii;
         count++;
      end

      res.iterations = count[8:0];
      res.inside_res = (count == MAX_ITER);
      if (count == MAX_ITER) begin
         res.red = grey ? 8'hff : 8'h00;
         res.green = res.red;
         res.blue = res.red;
      end else if (!grey) begin
         scale = (mec_pkg::HUE_PERIOD * cycles) / MAX_ITER;
         phase = (count * scale) % mec_pkg::HUE_PERIOD;
         if (phase <= mec_pkg::SEG_1) begin
            res.red = 8'h00;
            res.green = phase[7:0];
            res.blue = 8'hff;
         end else if (phase <= mec_pkg::SEG_2) begin
            res.red = 8'h00;
            res.green = 8'hff;
            res.blue = 8'(mec_pkg::SEG_2 - phase);
         end else if (phase <= mec_pkg::SEG_3) begin
            res.red = 8'(phase - mec_pkg::SEG_2);
            res.green = 8'hff;
            res.blue = 8'h00;
         end else if (phase <= mec_pkg::SEG_4) begin
            res.red = 8'hff;
            res.green = 8'(mec_pkg::SEG_4 - phase);
            res.blue = 8'h00;
         end else if (phase <= mec_pkg::SEG_5) begin
            res.red = 8'hff;
            res.green = 8'h00;
            res.blue = 8'(phase - mec_pkg::SEG_4);
         end else begin
            res.red = 8'(mec_pkg::SEG_6 - phase);
            res.green = 8'h00;
            res.blue = 8'hff;
         end
      end else begin
         scale = (mec_pkg::GREY_PERIOD * cycles) / MAX_ITER;
         phase = (count * scale) % mec_pkg::GREY_PERIOD;
         shade = (phase < mec_pkg::SEG_1) ? phase : mec_pkg::GREY_PERIOD - phase;
         res.red = shade[7:0];
         res.green = shade[7:0];
         res.blue = shade[7:0];
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         origin_re = mec_pkg::ORIGIN_RESET;
         origin_im = mec_pkg::ORIGIN_RESET;
         step_re = mec_pkg::STEP_RESET;
         step_im = mec_pkg::STEP_RESET;
         cycles = mec_pkg::CYCLES_RESET;
         grey = 1'b0;
         pending_pixels.delete();
         error_count = 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mec_pkg::CSR_ORIGIN_REAL:    origin_re = csr_wdata;
               mec_pkg::CSR_ORIGIN_IMAG:    origin_im = csr_wdata;
               mec_pkg::CSR_STEP_REAL:      step_re = csr_wdata[30:0];
               mec_pkg::CSR_STEP_IMAG:      step_im = csr_wdata[30:0];
               mec_pkg::CSR_PALETTE_CYCLES: cycles = csr_wdata[6:0];
               mec_pkg::CSR_GREY_MODE:      grey = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending_pixels.push_back(colour_pixel(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("rsp transaction with no pixel pending: %h", rsp_data);
               error_count++;
            end else begin
               oldest = pending_pixels.pop_front();
               check_field("iterations", 32'(oldest.iterations), 32'(rsp_data.iterations));
               check_field("inside_res", 32'(oldest.inside_res), 32'(rsp_data.inside_res));
               check_field("red", 32'(oldest.red), 32'(rsp_data.red));
               check_field("green", 32'(oldest.green), 32'(rsp_data.green));
               check_field("blue", 32'(oldest.blue), 32'(rsp_data.blue));
            end
         end
         pending_count <= pending_pixels.size();
      end
   end

endmodule

// File: verif/mandelbrot_escape_time_colorizer_top_tb.sv
// testbench top of the escape-time colorizer: clock, reset, pixel and register stimulus,
// result back-pressure and the verdict
// depends on mec_pkg, mandelbrot_escape_time_colorizer_top, mec_pixel_checker
`timescale 1ns / 100ps
module mandelbrot_escape_time_colorizer_top_tb;

   localparam int unsigned MAX_ITER        = 256;
   localparam int unsigned COLUMNS         = 1024;
   localparam int unsigned ROWS            = 1024;
   localparam int unsigned FRACTION_BITS   = 28;
   localparam int unsigned RSP_HOLD_CYCLES = 3000;
   localparam int unsigned DRAIN_CYCLES    = 2 * (MAX_ITER + 3);

   localparam logic [mec_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [mec_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_HALF,
      SINK_MOSTLY,
      SINK_SPARSE
   } sink_mode_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   mec_pkg::req_payload_type        req_data  = '0;
   logic                            rsp_ready = 1'b0;
   logic                            csr_valid = 1'b0;
   logic [mec_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mec_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_ready;
   logic                            rsp_valid;
   mec_pkg::rsp_payload_type        rsp_data;
   logic                            csr_ready;
   int                              error_count;
   int                              pending_count;
   int                              hold_asked = 0;
   int unsigned                     burst_left = 0;

   mandelbrot_escape_time_colorizer_top #(
      .MAX_ITER(MAX_ITER),
      .COLUMNS(COLUMNS),
      .ROWS(ROWS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   mec_pixel_checker #(
      .MAX_ITER(MAX_ITER),
      .COLUMNS(COLUMNS),
      .ROWS(ROWS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
      int unsigned roll;
      int unsigned gap;
      req_valid <= 1'b1;
      req_data <= {col, row};
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            gap = 0;
         end else if (roll < 88) begin
            gap = $urandom_range(1, 12);
         end else begin
            gap = $urandom_range(13, 300);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic run_pixels(input int unsigned count);
      logic [9:0] col;
      logic [9:0] row;
      for (int unsigned i = 0; i < count; i++) begin
         col = 10'($urandom_range(0, COLUMNS - 1));
         row = 10'($urandom_range(0, ROWS - 1));
         if ($urandom_range(0, 15) == 0) col = {10{col[0]}};
         if ($urandom_range(0, 15) == 0) row = {10{row[0]}};
         send_pixel(col, row);
      end
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input logic [mec_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mec_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_view(input logic signed [31:0] ore, input logic signed [31:0] oim,
                           input logic [30:0] sre, input logic [30:0] sim,
                           input logic [6:0] pal, input logic grey);
      logic [31:0] junk;
      junk = $urandom();
      write_reg(mec_pkg::CSR_ORIGIN_REAL, ore);
      write_reg(mec_pkg::CSR_ORIGIN_IMAG, oim);
      write_reg(mec_pkg::CSR_STEP_REAL, {junk[31], sre});
      write_reg(mec_pkg::CSR_STEP_IMAG, {junk[30], sim});
      write_reg(mec_pkg::CSR_PALETTE_CYCLES, {junk[24:0], pal});
      write_reg(mec_pkg::CSR_GREY_MODE, {junk[31:1], grey});
      write_reg(junk[0] ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom());
   endtask

   initial begin : rsp_sink
      int unsigned   stretch;
      int            hold_served;
      sink_mode_type mode;
      stretch = 0;
      hold_served = 0;
      mode = SINK_OPEN;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_served + 1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               mode = sink_mode_type'($urandom_range(0, 3));
               stretch = $urandom_range(1, 200);
            end
            stretch = stretch - 1;
            case (mode)
               SINK_OPEN:   rsp_ready <= 1'b1;
               SINK_HALF:   rsp_ready <= ($urandom_range(0, 1) == 0);
               SINK_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               default:     rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #30_000_000;
      $display("mandelbrot_escape_time_colorizer_top_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      logic [6:0] pal;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: origin -2 - 2i, 1/256 per pixel, hue palette
      send_pixel(10'd0, 10'd0);
      send_pixel(10'h3ff, 10'h3ff);
      send_pixel(10'd0, 10'h3ff);
      send_pixel(10'h3ff, 10'd0);
      send_pixel(10'd0, 10'd512);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd384, 10'd512);
      send_pixel(10'd256, 10'd512);
      send_pixel(10'd576, 10'd512);
      send_pixel(10'd579, 10'd512);
      send_pixel(10'd448, 10'd640);
      send_pixel(10'h155, 10'h2aa);
      send_pixel(10'h2aa, 10'h155);
      run_pixels(150);
      wait_results();

      set_view(-32'sd536870912, -32'sd536870912, 31'd1048576, 31'd1048576, 7'd1, 1'b1);
      run_pixels(150);
      wait_results();

      set_view(-32'sd209379738, 32'sd13421773, 31'd16384, 31'd16384, 7'd64, 1'b0);
      hold_asked <= hold_asked + 1;
      run_pixels(200);
      wait_results();

      set_view(-32'sd671088640, -32'sd335544320, 31'd838861, 31'd838861, 7'd127, 1'b0);
      run_pixels(150);
      wait_results();

      set_view(-32'sd536870912, -32'sd536870912, 31'd1048576, 31'd1048576, 7'd0, 1'b1);
      run_pixels(100);
      wait_results();

      set_view(32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 7'd64, 1'b0);
      send_pixel(10'd1, 10'd1);
      send_pixel(10'd0, 10'd1);
      send_pixel(10'd1, 10'd0);
      run_pixels(100);
      wait_results();

      set_view(32'sh7fff_ffff, 32'sh7fff_ffff, 31'd0, 31'd0, 7'd1, 1'b1);
      run_pixels(60);
      wait_results();

      set_view(-32'sd536870912, 32'sd0, 31'd1048576, 31'd0, 7'd1, 1'b1);
      run_pixels(100);
      wait_results();

      for (int p = 0; p < 4; p++) begin
         pal = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(1, 64));
         set_view(32'(-671088640 + $urandom_range(0, 805306368)),
                  32'(-402653184 + $urandom_range(0, 536870912)),
                  31'($urandom_range(1024, 1048576)), 31'($urandom_range(1024, 1048576)),
                  pal, 1'($urandom_range(0, 1)));
         if (p == 1) hold_asked <= hold_asked + 1;
         run_pixels(125);
         wait_results();
      end

      set_view(32'($urandom()), 32'($urandom()), 31'($urandom()), 31'($urandom()),
               7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      run_pixels(100);
      wait_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("mandelbrot_escape_time_colorizer_top_tb OK");
      end else begin
         $display("mandelbrot_escape_time_colorizer_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: mandelbrot_escape_time_colorizer_top.f
src/mec_pkg.sv
src/mec_front.sv
src/mec_fifo.sv
src/mec_engine.sv
src/mandelbrot_escape_time_colorizer_top.sv
verif/mec_pixel_checker.sv
verif/mandelbrot_escape_time_colorizer_top_tb.sv
